// ===== rtl/scalc_pkg.sv =====
`default_nettype none

package scalc_pkg;

	// default sizes of the stack and of one word
	localparam int STACK_DEPTH_DEF = 1024;
	localparam int DATA_WIDTH_DEF  = 32;

	// command codes of the input word
	typedef enum logic [2:0] {
		CMD_PUSH     = 3'd0,
		CMD_POP      = 3'd1,
		CMD_PEEK_TOP = 3'd2,
		CMD_PEEK_BOT = 3'd3,
		CMD_ADD      = 3'd4,
		CMD_SUB      = 3'd5,
		CMD_MUL      = 3'd6,
		CMD_DIV      = 3'd7
	} cmd_t;

	// status codes of the result word
	typedef enum logic [2:0] {
		ST_OK    = 3'd0,
		ST_FULL  = 3'd1,
		ST_EMPTY = 3'd2,
		ST_RANGE = 3'd3,
		ST_FEW   = 3'd4,
		ST_DIVZ  = 3'd5
	} status_t;

	// stack memory address select
	typedef enum logic [2:0] {
		ADR_PUSH     = 3'd0,
		ADR_TOP      = 3'd1,
		ADR_SECOND   = 3'd2,
		ADR_PEEK_TOP = 3'd3,
		ADR_PEEK_BOT = 3'd4
	} addr_sel_t;

	// stack memory write data select
	typedef enum logic [1:0] {
		WR_PUSH = 2'd0,
		WR_ALU  = 2'd1,
		WR_MD   = 2'd2
	} wr_sel_t;

	// entry count update
	typedef enum logic [1:0] {
		CNT_HOLD = 2'd0,
		CNT_INC  = 2'd1,
		CNT_DEC  = 2'd2,
		CNT_DEC2 = 2'd3
	} cnt_op_t;

	// result value select
	typedef enum logic [1:0] {
		RES_ZERO = 2'd0,
		RES_READ = 2'd1,
		RES_ALU  = 2'd2,
		RES_MD   = 2'd3
	} res_sel_t;

	// controller to datapath commands
	typedef struct packed {
		logic      in_load;
		logic      mem_we;
		logic      mem_re;
		addr_sel_t addr_sel;
		wr_sel_t   wr_sel;
		cnt_op_t   cnt_op;
		logic      t_load;
		logic      md_start;
		logic      res_load;
		res_sel_t  res_sel;
		status_t   res_status;
		logic      out_load;
	} dp_ctrl_t;

	// datapath to controller status
	typedef struct packed {
		cmd_t cmd;
		logic full;
		logic empty;
		logic range_err;
		logic few;
		logic t_zero;
		logic md_done;
	} dp_stat_t;

endpackage

`default_nettype wire

// ===== rtl/scalc_muldiv.sv =====
`default_nettype none

// shared iterative unit: shift-add multiply (low half) or floor division,
// one bit per cycle
module scalc_muldiv #(
	parameter int DATA_WIDTH = scalc_pkg::DATA_WIDTH_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic                  is_div,
	input  wire logic [DATA_WIDTH-1:0] a,
	input  wire logic [DATA_WIDTH-1:0] b,
	output logic                       done,
	output logic [DATA_WIDTH-1:0]      result
);

	localparam int CNTW = $clog2(DATA_WIDTH + 1);

	logic                  busy_q;
	logic                  done_q;
	logic                  div_q;
	logic                  neg_q;
	logic [CNTW-1:0]       cnt_q;
	logic [DATA_WIDTH-1:0] acc_q;
	logic [DATA_WIDTH-1:0] x_q;
	logic [DATA_WIDTH-1:0] y_q;

	logic [DATA_WIDTH-1:0] mag_a;
	logic [DATA_WIDTH-1:0] mag_b;
	logic [DATA_WIDTH:0]   rem_sh;
	logic [DATA_WIDTH:0]   diff;
	logic [DATA_WIDTH-1:0] q_adj;

	// operand magnitudes; the most negative value maps onto itself, read unsigned
	assign mag_a = a[DATA_WIDTH-1] ? (~a + DATA_WIDTH'(1)) : a;
	assign mag_b = b[DATA_WIDTH-1] ? (~b + DATA_WIDTH'(1)) : b;

	// restoring division step
	assign rem_sh = {acc_q, y_q[DATA_WIDTH-1]};
	assign diff   = rem_sh - {1'b0, x_q};

	// floor correction when the signs differ
	assign q_adj = y_q + DATA_WIDTH'(acc_q != '0);

	assign done   = done_q;
	assign result = div_q ? (neg_q ? (~q_adj + DATA_WIDTH'(1)) : y_q) : acc_q;

	// iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNTW'(DATA_WIDTH);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNTW'(1);
				if (cnt_q == CNTW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// operand and partial result registers
	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= is_div;
			neg_q <= a[DATA_WIDTH-1] ^ b[DATA_WIDTH-1];
			acc_q <= '0;
			x_q   <= is_div ? mag_b : a;
			y_q   <= is_div ? mag_a : b;
		end else if (busy_q) begin
			if (div_q) begin
				if (!diff[DATA_WIDTH]) begin
					acc_q <= diff[DATA_WIDTH-1:0];
				end else begin
					acc_q <= rem_sh[DATA_WIDTH-1:0];
				end
				y_q <= {y_q[DATA_WIDTH-2:0], ~diff[DATA_WIDTH]};
			end else begin
				if (y_q[0]) begin
					acc_q <= acc_q + x_q;
				end
				x_q <= {x_q[DATA_WIDTH-2:0], 1'b0};
				y_q <= {1'b0, y_q[DATA_WIDTH-1:1]};
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/scalc_dp.sv =====
`default_nettype none

// datapath: command word registers, stack memory, entry count, alu,
// iterative unit and output word registers
module scalc_dp #(
	parameter int STACK_DEPTH = scalc_pkg::STACK_DEPTH_DEF,
	parameter int DATA_WIDTH  = scalc_pkg::DATA_WIDTH_DEF,
	localparam int AW = $clog2(STACK_DEPTH),
	localparam int CW = $clog2(STACK_DEPTH + 1)
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire scalc_pkg::dp_ctrl_t   ctl,
	output scalc_pkg::dp_stat_t        stat,
	input  wire logic [2:0]            command,
	input  wire logic [DATA_WIDTH-1:0] push_value,
	input  wire logic [AW-1:0]         position,
	output logic [DATA_WIDTH-1:0]      result_value,
	output logic [2:0]                 status,
	output logic [CW-1:0]              depth
);

	scalc_pkg::cmd_t       cmd_q;
	logic [DATA_WIDTH-1:0] pv_q;
	logic [AW-1:0]         pos_q;
	logic [CW-1:0]         count_q;
	logic [DATA_WIDTH-1:0] t_q;
	logic [DATA_WIDTH-1:0] rd_q;
	logic [DATA_WIDTH-1:0] res_value_q;
	scalc_pkg::status_t    res_status_q;
	logic [DATA_WIDTH-1:0] out_value_q;
	scalc_pkg::status_t    out_status_q;
	logic [CW-1:0]         out_depth_q;

	logic [DATA_WIDTH-1:0] mem [STACK_DEPTH];

	logic [CW-1:0]         cnt_m1;
	logic [CW-1:0]         cnt_m2;
	logic [CW-1:0]         pos_ext;
	logic [CW-1:0]         peek_idx;
	logic [AW-1:0]         addr;
	logic [DATA_WIDTH-1:0] alu;
	logic [DATA_WIDTH-1:0] wdata;
	logic [DATA_WIDTH-1:0] md_result;
	logic                  md_done;

	// index arithmetic on the entry count
	assign cnt_m1   = count_q - CW'(1);
	assign cnt_m2   = count_q - CW'(2);
	assign pos_ext  = CW'(pos_q);
	assign peek_idx = cnt_m1 - pos_ext;

	// add or subtract: second minus top
	assign alu = (cmd_q == scalc_pkg::CMD_SUB) ? (rd_q - t_q) : (rd_q + t_q);

	// status toward the controller
	assign stat.cmd       = cmd_q;
	assign stat.full      = (count_q == CW'(STACK_DEPTH));
	assign stat.empty     = (count_q == '0);
	assign stat.range_err = (pos_ext >= count_q);
	assign stat.few       = (count_q < CW'(2));
	assign stat.t_zero    = (t_q == '0);
	assign stat.md_done   = md_done;

	// memory address select
	always_comb begin
		unique case (ctl.addr_sel)
			scalc_pkg::ADR_PUSH:     addr = count_q[AW-1:0];
			scalc_pkg::ADR_TOP:      addr = cnt_m1[AW-1:0];
			scalc_pkg::ADR_SECOND:   addr = cnt_m2[AW-1:0];
			scalc_pkg::ADR_PEEK_TOP: addr = peek_idx[AW-1:0];
			scalc_pkg::ADR_PEEK_BOT: addr = pos_q;
			default:                 addr = count_q[AW-1:0];
		endcase
	end

	// memory write data select
	always_comb begin
		unique case (ctl.wr_sel)
			scalc_pkg::WR_PUSH: wdata = pv_q;
			scalc_pkg::WR_ALU:  wdata = alu;
			scalc_pkg::WR_MD:   wdata = md_result;
			default:            wdata = pv_q;
		endcase
	end

	// stack memory, one port, registered read
	always_ff @(posedge clk) begin
		if (ctl.mem_we) begin
			mem[addr] <= wdata;
		end
		if (ctl.mem_re) begin
			rd_q <= mem[addr];
		end
	end

	// entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			unique case (ctl.cnt_op)
				scalc_pkg::CNT_HOLD: count_q <= count_q;
				scalc_pkg::CNT_INC:  count_q <= count_q + CW'(1);
				scalc_pkg::CNT_DEC:  count_q <= cnt_m1;
				scalc_pkg::CNT_DEC2: count_q <= cnt_m2;
				default:             count_q <= count_q;
			endcase
		end
	end

	// input word, top operand, result staging and output word
	always_ff @(posedge clk) begin
		if (ctl.in_load) begin
			cmd_q <= scalc_pkg::cmd_t'(command);
			pv_q  <= push_value;
			pos_q <= position;
		end
		if (ctl.t_load) begin
			t_q <= rd_q;
		end
		if (ctl.res_load) begin
			res_status_q <= ctl.res_status;
			unique case (ctl.res_sel)
				scalc_pkg::RES_ZERO: res_value_q <= '0;
				scalc_pkg::RES_READ: res_value_q <= rd_q;
				scalc_pkg::RES_ALU:  res_value_q <= alu;
				scalc_pkg::RES_MD:   res_value_q <= md_result;
				default:             res_value_q <= '0;
			endcase
		end
		if (ctl.out_load) begin
			out_value_q  <= res_value_q;
			out_status_q <= res_status_q;
			out_depth_q  <= count_q;
		end
	end

	// multiply and divide unit, operands are second and top
	scalc_muldiv #(
		.DATA_WIDTH(DATA_WIDTH)
	) u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ctl.md_start),
		.is_div (cmd_q == scalc_pkg::CMD_DIV),
		.a      (rd_q),
		.b      (t_q),
		.done   (md_done),
		.result (md_result)
	);

	assign result_value = out_value_q;
	assign status       = out_status_q;
	assign depth        = out_depth_q;

endmodule

`default_nettype wire

// ===== rtl/scalc_ctrl.sv =====
`default_nettype none

// controller: sequences one command word through the datapath and owns the
// handshakes of both channels
module scalc_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	output logic                     out_valid,
	input  wire logic                out_ready,
	input  wire scalc_pkg::dp_stat_t stat,
	output scalc_pkg::dp_ctrl_t      ctl
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_RD_WAIT,
		S_RD_T,
		S_RD_S,
		S_ITER,
		S_EMIT
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	// command decode per state
	always_comb begin
		ctl     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					ctl.in_load = 1'b1;
					state_d     = S_DECODE;
				end
			end
			S_DECODE: begin
				state_d = S_EMIT;
				unique case (stat.cmd) inside
					scalc_pkg::CMD_PUSH: begin
						ctl.res_load = 1'b1;
						ctl.res_sel  = scalc_pkg::RES_ZERO;
						if (stat.full) begin
							ctl.res_status = scalc_pkg::ST_FULL;
						end else begin
							ctl.res_status = scalc_pkg::ST_OK;
							ctl.mem_we     = 1'b1;
							ctl.addr_sel   = scalc_pkg::ADR_PUSH;
							ctl.wr_sel     = scalc_pkg::WR_PUSH;
							ctl.cnt_op     = scalc_pkg::CNT_INC;
						end
					end
					scalc_pkg::CMD_POP: begin
						if (stat.empty) begin
							ctl.res_load   = 1'b1;
							ctl.res_sel    = scalc_pkg::RES_ZERO;
							ctl.res_status = scalc_pkg::ST_EMPTY;
						end else begin
							ctl.mem_re   = 1'b1;
							ctl.addr_sel = scalc_pkg::ADR_TOP;
							ctl.cnt_op   = scalc_pkg::CNT_DEC;
							state_d      = S_RD_WAIT;
						end
					end
					scalc_pkg::CMD_PEEK_TOP, scalc_pkg::CMD_PEEK_BOT: begin
						if (stat.range_err) begin
							ctl.res_load   = 1'b1;
							ctl.res_sel    = scalc_pkg::RES_ZERO;
							ctl.res_status = scalc_pkg::ST_RANGE;
						end else begin
							ctl.mem_re   = 1'b1;
							ctl.addr_sel = (stat.cmd == scalc_pkg::CMD_PEEK_TOP) ?
								scalc_pkg::ADR_PEEK_TOP : scalc_pkg::ADR_PEEK_BOT;
							state_d      = S_RD_WAIT;
						end
					end
					default: begin
						// arithmetic: fetch top first
						if (stat.few) begin
							ctl.res_load   = 1'b1;
							ctl.res_sel    = scalc_pkg::RES_ZERO;
							ctl.res_status = scalc_pkg::ST_FEW;
						end else begin
							ctl.mem_re   = 1'b1;
							ctl.addr_sel = scalc_pkg::ADR_TOP;
							state_d      = S_RD_T;
						end
					end
				endcase
			end
			S_RD_WAIT: begin
				ctl.res_load   = 1'b1;
				ctl.res_sel    = scalc_pkg::RES_READ;
				ctl.res_status = scalc_pkg::ST_OK;
				state_d        = S_EMIT;
			end
			S_RD_T: begin
				ctl.t_load   = 1'b1;
				ctl.mem_re   = 1'b1;
				ctl.addr_sel = scalc_pkg::ADR_SECOND;
				state_d      = S_RD_S;
			end
			S_RD_S: begin
				unique case (stat.cmd) inside
					scalc_pkg::CMD_ADD, scalc_pkg::CMD_SUB: begin
						ctl.mem_we     = 1'b1;
						ctl.addr_sel   = scalc_pkg::ADR_SECOND;
						ctl.wr_sel     = scalc_pkg::WR_ALU;
						ctl.cnt_op     = scalc_pkg::CNT_DEC;
						ctl.res_load   = 1'b1;
						ctl.res_sel    = scalc_pkg::RES_ALU;
						ctl.res_status = scalc_pkg::ST_OK;
						state_d        = S_EMIT;
					end
					scalc_pkg::CMD_DIV: begin
						if (stat.t_zero) begin
							// operands consumed, nothing pushed
							ctl.cnt_op     = scalc_pkg::CNT_DEC2;
							ctl.res_load   = 1'b1;
							ctl.res_sel    = scalc_pkg::RES_ZERO;
							ctl.res_status = scalc_pkg::ST_DIVZ;
							state_d        = S_EMIT;
						end else begin
							ctl.md_start = 1'b1;
							state_d      = S_ITER;
						end
					end
					default: begin
						ctl.md_start = 1'b1;
						state_d      = S_ITER;
					end
				endcase
			end
			S_ITER: begin
				if (stat.md_done) begin
					ctl.mem_we     = 1'b1;
					ctl.addr_sel   = scalc_pkg::ADR_SECOND;
					ctl.wr_sel     = scalc_pkg::WR_MD;
					ctl.cnt_op     = scalc_pkg::CNT_DEC;
					ctl.res_load   = 1'b1;
					ctl.res_sel    = scalc_pkg::RES_MD;
					ctl.res_status = scalc_pkg::ST_OK;
					state_d        = S_EMIT;
				end
			end
			S_EMIT: begin
				// move the staged word out once the output register is free
				if (!out_valid_q || out_ready) begin
					ctl.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/stack_calculator_engine.sv =====
`default_nettype none

// Stack calculator: a stack of STACK_DEPTH signed words with add, subtract,
// multiply and floor divide on the two top entries.
// Input channel (in_valid/in_ready) takes one command word: command,
// push_value and position. Output channel (out_valid/out_ready) gives one
// result word per command: result_value, status and depth after the command.
// One command is worked on at a time; in_ready is high only while idle.
// Push and most error words go from decode straight to the result word;
// pop and peek add a wait for the memory read; add, subtract and divide by
// zero read top and then second; multiply and divide then also run the
// one-bit-per-cycle multiply/divide unit, which sets the worst case. The
// single port stack memory with registered read sets the path of the stack
// commands. The block is idle again as the result word turns valid.
// The result sits in an output register: a new command is accepted while it
// waits, and a stalled receiver only holds the next command before its final
// hand-off to that register.
// Reset clears the entry count, the controller state and out_valid; the stack
// memory is not cleared, since no entry is read before it is written.
module stack_calculator_engine #(
	parameter int STACK_DEPTH = scalc_pkg::STACK_DEPTH_DEF,
	parameter int DATA_WIDTH  = scalc_pkg::DATA_WIDTH_DEF,
	localparam int AW = $clog2(STACK_DEPTH),
	localparam int CW = $clog2(STACK_DEPTH + 1)
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [2:0]                   command,
	input  wire logic signed [DATA_WIDTH-1:0] push_value,
	input  wire logic [AW-1:0]                position,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic signed [DATA_WIDTH-1:0]      result_value,
	output logic [2:0]                        status,
	output logic [CW-1:0]                     depth
);

	scalc_pkg::dp_ctrl_t ctl;
	scalc_pkg::dp_stat_t stat;

	scalc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.ctl       (ctl)
	);

	scalc_dp #(
		.STACK_DEPTH(STACK_DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.stat         (stat),
		.command      (command),
		.push_value   (push_value),
		.position     (position),
		.result_value (result_value),
		.status       (status),
		.depth        (depth)
	);

	// depth never exceeds the stack size
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (depth <= CW'(STACK_DEPTH)))
		else $error("depth beyond stack size");

	// any error word carries a zero value
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status != scalc_pkg::ST_OK)) |-> (result_value == '0))
		else $error("error word with nonzero value");

	// one command at a time: no accept right after an accept
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("second command taken while busy");

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
`default_nettype none

module testbench;
	import scalc_pkg::*;

	localparam int STACK_WORDS  = STACK_DEPTH_DEF;
	localparam int IDLE_LIMIT   = 5000;
	localparam int TAIL_CYCLES  = 48;

	// one command word as queued for the driver
	typedef struct {
		cmd_t               cmd;
		logic signed [31:0] value;
		logic [9:0]         pos;
		bit                 wait_idle;
	} stack_cmd_t;

	// one result word as predicted
	typedef struct {
		logic signed [31:0] value;
		status_t            code;
		logic [10:0]        depth;
	} calc_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [2:0]         command = CMD_PUSH;
	logic signed [31:0] push_value = '0;
	logic [9:0]         position = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic signed [31:0] result_value;
	logic [2:0]         status;
	logic [10:0]        depth;

	stack_cmd_t   pending_cmds[$];
	calc_result_t expected_results[$];

	// shadow stack of the calculator
	logic signed [31:0] shadow_stack [STACK_WORDS];
	int                 shadow_count = 0;

	int failures = 0;
	int accepted_cmds = 0;
	int checked_results = 0;
	int deepest = 0;
	int status_seen [6] = '{default: 0};
	int gap_left = 0;
	int burst_left = 0;
	int stall_mode = 0;
	int pattern_left = 0;
	int idle_cycles = 0;

	stack_calculator_engine uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.command      (command),
		.push_value   (push_value),
		.position     (position),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.result_value (result_value),
		.status       (status),
		.depth        (depth)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// floor division of two signed words, min / -1 wraps
	function automatic logic signed [31:0] floor_quotient(logic signed [31:0] num,
		logic signed [31:0] den);
		longint n;
		longint d;
		longint q;
		longint r;
		n = num;
		d = den;
		q = n / d;
		r = n % d;
		if (r != 0 && ((r < 0) != (d < 0)))
			q = q - 1;
		return q[31:0];
	endfunction

	// apply one command to the shadow stack and give the result word
	function automatic calc_result_t predict_result(cmd_t cmd, logic signed [31:0] pv,
		logic [9:0] pos);
		calc_result_t res;
		logic signed [31:0] top_word;
		logic signed [31:0] second_word;
		res.value = '0;
		res.code = ST_OK;
		case (cmd)
			CMD_PUSH: begin
				if (shadow_count >= STACK_WORDS)
					res.code = ST_FULL;
				else begin
					shadow_stack[shadow_count] = pv;
					shadow_count++;
				end
			end
			CMD_POP: begin
				if (shadow_count == 0)
					res.code = ST_EMPTY;
				else begin
					shadow_count--;
					res.value = shadow_stack[shadow_count];
				end
			end
			CMD_PEEK_TOP: begin
				if (pos >= shadow_count)
					res.code = ST_RANGE;
				else
					res.value = shadow_stack[shadow_count - 1 - pos];
			end
			CMD_PEEK_BOT: begin
				if (pos >= shadow_count)
					res.code = ST_RANGE;
				else
					res.value = shadow_stack[pos];
			end
			default: begin
				if (shadow_count < 2)
					res.code = ST_FEW;
				else begin
					top_word = shadow_stack[shadow_count - 1];
					second_word = shadow_stack[shadow_count - 2];
					shadow_count -= 2;
					case (cmd)
						CMD_ADD: res.value = second_word + top_word;
						CMD_SUB: res.value = second_word - top_word;
						CMD_MUL: res.value = second_word * top_word;
						default: begin
							if (top_word == 0)
								res.code = ST_DIVZ;
							else
								res.value = floor_quotient(second_word, top_word);
						end
					endcase
					if (res.code == ST_OK) begin
						shadow_stack[shadow_count] = res.value;
						shadow_count++;
					end
				end
			end
		endcase
		res.depth = shadow_count[10:0];
		return res;
	endfunction

	task automatic queue_cmd(cmd_t cmd, logic signed [31:0] value, logic [9:0] pos,
		bit wait_idle = 1'b0);
		stack_cmd_t item;
		item.cmd = cmd;
		item.value = value;
		item.pos = pos;
		item.wait_idle = wait_idle;
		pending_cmds.push_back(item);
	endtask

	// operand mix: full range, small values, zero and extremes
	function automatic logic signed [31:0] random_word();
		int r;
		r = $urandom_range(0, 9);
		if (r < 4)
			return $urandom;
		else if (r < 7)
			return $signed($urandom_range(0, 64)) - 32;
		else if (r == 7)
			return '0;
		else if (r == 8)
			return ($urandom_range(0, 1) != 0) ? 32'sh7fffffff : 32'sh80000000;
		else
			return ($urandom_range(0, 1) != 0) ? 32'sh00000001 : 32'shffffffff;
	endfunction

	function automatic logic [9:0] random_pos();
		if ($urandom_range(0, 9) < 6)
			return 10'($urandom_range(0, 8));
		return 10'($urandom_range(0, 1023));
	endfunction

	function automatic cmd_t random_arith();
		case ($urandom_range(0, 3))
			0: return CMD_ADD;
			1: return CMD_SUB;
			2: return CMD_MUL;
			default: return CMD_DIV;
		endcase
	endfunction

	// pick a command with the given weights in percent
	task automatic queue_random(int push_pct, int arith_pct);
		int r;
		cmd_t cmd;
		r = $urandom_range(0, 99);
		if (r < push_pct)
			cmd = CMD_PUSH;
		else if (r < push_pct + arith_pct)
			cmd = random_arith();
		else begin
			case ($urandom_range(0, 2))
				0: cmd = CMD_POP;
				1: cmd = CMD_PEEK_TOP;
				default: cmd = CMD_PEEK_BOT;
			endcase
		end
		queue_cmd(cmd, random_word(), random_pos());
	endtask

	// word driver: bursts with random gaps between them
	always @(posedge clk or negedge arst_n) begin : word_driver
		stack_cmd_t item;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				expected_results.push_back(predict_result(cmd_t'(command), push_value, position));
				accepted_cmds++;
			end
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else if (pending_cmds.size() > 0 &&
					!(pending_cmds[0].wait_idle && expected_results.size() > 0)) begin
					item = pending_cmds.pop_front();
					command <= item.cmd;
					push_value <= item.value;
					position <= item.pos;
					in_valid <= 1'b1;
					if (burst_left == 0) begin
						burst_left <= $urandom_range(0, 24);
						gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// word monitor: compare each result word with the oldest prediction
	always @(posedge clk or negedge arst_n) begin : word_monitor
		calc_result_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$error("result word with nothing expected: value %0d status %0d depth %0d",
						result_value, status, depth);
					failures++;
				end else begin
					want = expected_results.pop_front();
					checked_results++;
					if (result_value !== want.value) begin
						$error("result_value: expected %0d, actual %0d", want.value, result_value);
						failures++;
					end
					if (status !== want.code) begin
						$error("status: expected %0d, actual %0d", want.code, status);
						failures++;
					end
					if (depth !== want.depth) begin
						$error("depth: expected %0d, actual %0d", want.depth, depth);
						failures++;
					end
				end
				if (status < 6)
					status_seen[status]++;
				if (depth > deepest)
					deepest = depth;
			end
			// receiver stall pattern, a new mode whenever the pattern count runs out
			if (pattern_left == 0) begin
				stall_mode <= $urandom_range(0, 3);
				pattern_left <= $urandom_range(32, 256);
			end else begin
				pattern_left <= pattern_left - 1;
			end
			case (stall_mode)
				0: out_ready <= 1'b1;
				1: out_ready <= ($urandom_range(0, 1) != 0);
				2: out_ready <= ($urandom_range(0, 7) == 0);
				default: out_ready <= (pattern_left % 16 < 4);
			endcase
		end
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	initial begin
		int pushes;

		// directed: errors on an empty stack
		queue_cmd(CMD_POP, 32'sh0, 10'd0);
		queue_cmd(CMD_PEEK_TOP, 32'shffffffff, 10'd0);
		queue_cmd(CMD_PEEK_BOT, 32'sh0, 10'd1023);
		queue_cmd(CMD_ADD, 32'sh0, 10'd0);
		// one operand only, then add of the two extremes
		queue_cmd(CMD_PUSH, 32'sh7fffffff, 10'd0);
		queue_cmd(CMD_DIV, 32'sh0, 10'd0);
		queue_cmd(CMD_PUSH, 32'sh80000000, 10'd0);
		queue_cmd(CMD_ADD, 32'sh0, 10'd0);
		// most negative divided by minus one
		queue_cmd(CMD_PUSH, 32'shffffffff, 10'd0);
		queue_cmd(CMD_PUSH, 32'sh80000000, 10'd0);
		queue_cmd(CMD_PUSH, 32'shffffffff, 10'd0);
		queue_cmd(CMD_DIV, 32'sh0, 10'd0);
		// peeks in and out of range
		queue_cmd(CMD_PEEK_TOP, 32'sh0, 10'd0);
		queue_cmd(CMD_PEEK_BOT, 32'sh0, 10'd0);
		queue_cmd(CMD_PEEK_TOP, 32'sh0, 10'd2);
		queue_cmd(CMD_PEEK_TOP, 32'sh0, 10'd3);
		// divide by zero still consumes both operands
		queue_cmd(CMD_PUSH, 32'sh0, 10'd0);
		queue_cmd(CMD_DIV, 32'sh0, 10'd0);
		// floor rounding toward minus infinity
		queue_cmd(CMD_PUSH, 32'sh7, 10'd0);
		queue_cmd(CMD_PUSH, -32'sh2, 10'd0);
		queue_cmd(CMD_DIV, 32'sh0, 10'd0);
		queue_cmd(CMD_SUB, 32'sh0, 10'd0);
		queue_cmd(CMD_MUL, 32'sh0, 10'd0);
		queue_cmd(CMD_POP, 32'sh0, 10'd0);
		queue_cmd(CMD_POP, 32'sh0, 10'd0);

		// shallow mix, first word waits for the block to go idle
		queue_cmd(CMD_PUSH, random_word(), random_pos(), 1'b1);
		repeat (250)
			queue_random(35, 30);

		// fill the stack to the top with a few peeks on the way
		queue_cmd(CMD_PUSH, random_word(), random_pos(), 1'b1);
		pushes = 1;
		while (pushes < STACK_WORDS + 4) begin
			if ($urandom_range(0, 99) < 8) begin
				queue_cmd(($urandom_range(0, 1) != 0) ? CMD_PEEK_TOP : CMD_PEEK_BOT,
					random_word(), 10'($urandom_range(0, 1023)));
			end else begin
				queue_cmd(CMD_PUSH, random_word(), random_pos());
				pushes++;
			end
		end
		// full stack: reject pushes, deepest peeks
		queue_cmd(CMD_PUSH, 32'sh7fffffff, 10'd1023);
		queue_cmd(CMD_PEEK_BOT, 32'sh0, 10'd1023);
		queue_cmd(CMD_PEEK_TOP, 32'sh0, 10'd1023);
		queue_cmd(CMD_PEEK_BOT, 32'sh0, 10'($urandom_range(0, 1023)));

		// arithmetic-heavy drain, then a final shallow mix
		repeat (80)
			queue_random(20, 60);
		repeat (150)
			queue_random(35, 30);

		// reset
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_cmds.size() != 0 || in_valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d commands and %0d result words, deepest stack %0d",
			accepted_cmds, checked_results, deepest);
		$display("status seen: ok %0d full %0d empty %0d range %0d few %0d divz %0d",
			status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_EMPTY],
			status_seen[ST_RANGE], status_seen[ST_FEW], status_seen[ST_DIVZ]);
		if (failures == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

`default_nettype wire
